// File: hdl/cpr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Clock page replacement package
// Shared widths, operation and result codes, and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package cpr_pkg;

    localparam int FRAME_W        = 6;
    localparam int PAGES_W        = 7;
    localparam int OP_W           = 2;
    localparam int KIND_W         = 2;
    localparam int MAX_FRAMES_DEF = 64;
    localparam int PAGES_RESET    = 64;
    localparam int MIN_PAGES      = 2;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_REF     = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_GRANT  = 2'd0,
        KIND_UNMAP  = 2'd1,
        KIND_VICTIM = 2'd2,
        KIND_ACK    = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_step;
        logic latch;
        logic reord_start;
        logic reord_run;
        logic grant_fin;
        logic sweep_rd;
        logic sweep_eval;
        logic ack_apply;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic            init_last;
        logic [OP_W-1:0] op;
        logic            free_avail;
        logic            reord_done;
        logic            sweep_hit;
        logic            out_free;
    } t_status;

endpackage

// File: hdl/cpr_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// Clock page replacement controller
// Sequences the clearing pass, request decode, ring reordering on a grant,
// the hand sweep and the acknowledge of reference and release requests.
// ============================================================================
module cpr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output cpr_pkg::t_cmd    o_cmd,
    input  cpr_pkg::t_status i_status
);
    import cpr_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_REORD,
        S_GRANT,
        S_SWEEP_RD,
        S_SWEEP_EV,
        S_ACK
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_status.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.op == OP_ALLOC) begin
                    if (i_status.free_avail) begin
                        o_cmd.reord_start = 1'b1;
                        n_state           = S_REORD;
                    end else begin
                        n_state = S_SWEEP_RD;
                    end
                end else begin
                    n_state = S_ACK;
                end
            end
            S_REORD: begin
                o_cmd.reord_run = 1'b1;
                if (i_status.reord_done) begin
                    n_state = S_GRANT;
                end
            end
            S_GRANT: begin
                if (i_status.out_free) begin
                    o_cmd.grant_fin = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SWEEP_RD: begin
                o_cmd.sweep_rd = 1'b1;
                n_state        = S_SWEEP_EV;
            end
            S_SWEEP_EV: begin
                if (i_status.out_free) begin
                    o_cmd.sweep_eval = 1'b1;
                    n_state          = i_status.sweep_hit ? S_SWEEP_RD : S_IDLE;
                end
            end
            S_ACK: begin
                if (i_status.out_free) begin
                    o_cmd.ack_apply = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        // A register write restarts the clearing pass.
        if (i_cfg_we) begin
            o_cmd   = '0;
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: hdl/cpr_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// Clock page replacement datapath
// Holds the double-banked ring memory, the free list memory, the reference
// and dirty bits, the hand and the result register.
// ============================================================================
module cpr_dpath #(
    parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cpr_pkg::PAGES_W-1:0]  i_cfg_data,
    input  logic [cpr_pkg::OP_W-1:0]     i_op,
    input  logic [cpr_pkg::FRAME_W-1:0]  i_frame,
    input  logic                         i_is_write,
    input  cpr_pkg::t_cmd                i_cmd,
    output cpr_pkg::t_status             o_status,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [cpr_pkg::KIND_W-1:0]   o_kind,
    output logic [cpr_pkg::FRAME_W-1:0]  o_frame_out,
    output logic                         o_needs_writeback,
    output logic                         o_last
);
    import cpr_pkg::*;

    localparam int AW          = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW          = $clog2(MAX_FRAMES + 1);
    localparam int RESET_PAGES = (PAGES_RESET > MAX_FRAMES) ? MAX_FRAMES : PAGES_RESET;
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_FRAMES - 1);

    // Memories.
    logic [AW-1:0] r_ring0 [MAX_FRAMES];
    logic [AW-1:0] r_ring1 [MAX_FRAMES];
    logic [AW-1:0] r_free_mem [MAX_FRAMES];

    // Control state.
    logic [CW-1:0]         r_pages;
    logic [CW-1:0]         n_pages;
    logic                  r_bank;
    logic [AW-1:0]         r_hand;
    logic [AW-1:0]         r_rp;
    logic [AW-1:0]         r_krd;
    logic [AW-1:0]         r_j;
    logic                  r_rq_vld;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_tail;
    logic [CW-1:0]         r_count;
    logic [MAX_FRAMES-1:0] r_ref;
    logic [MAX_FRAMES-1:0] r_dirty;
    logic [AW-1:0]         r_idx;
    logic                  r_out_valid;

    // Payload.
    logic [AW-1:0]      r_ring_q;
    logic [AW-1:0]      r_free_q;
    logic [OP_W-1:0]    r_op;
    logic [FRAME_W-1:0] r_frame;
    logic               r_wr;
    t_kind              r_kind;
    logic [FRAME_W-1:0] r_frame_out;
    logic               r_wb;
    logic               r_last;

    logic [AW-1:0] ring_len;
    logic [AW-1:0] hand_inc;
    logic [AW-1:0] rp_inc;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;
    logic [AW-1:0] fi;
    logic          frame_ok;
    logic          can_push;
    logic          reord_rd;
    logic          reord_keep;
    logic          ring_rd;
    logic [AW-1:0] ring_ra;
    logic          w_we;
    logic          w_sel;
    logic [AW-1:0] w_addr;
    logic [AW-1:0] w_data;
    logic          f_we;
    logic [AW-1:0] f_addr;
    logic [AW-1:0] f_data;
    logic          out_load;
    logic          hit;

    always_comb begin
        if (i_cfg_data < PAGES_W'(MIN_PAGES)) begin
            n_pages = CW'(MIN_PAGES);
        end else if (i_cfg_data > PAGES_W'(MAX_FRAMES)) begin
            n_pages = CW'(MAX_FRAMES);
        end else begin
            n_pages = CW'(i_cfg_data);
        end
    end

    assign ring_len   = AW'(r_pages - 1'b1);
    assign hand_inc   = (r_hand == ring_len - 1'b1) ? '0 : r_hand + 1'b1;
    assign rp_inc     = (r_rp == ring_len - 1'b1) ? '0 : r_rp + 1'b1;
    assign head_inc   = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_inc   = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign fi         = r_frame[AW-1:0];
    assign frame_ok   = (r_frame != '0) && (PAGES_W'(r_frame) < PAGES_W'(r_pages));
    assign can_push   = (r_count != CW'(MAX_FRAMES));
    assign reord_rd   = i_cmd.reord_run && (r_krd != ring_len);
    assign reord_keep = i_cmd.reord_run && r_rq_vld && (r_ring_q != r_free_q);
    assign ring_rd    = i_cmd.sweep_rd || reord_rd;
    assign ring_ra    = i_cmd.sweep_rd ? r_hand : r_rp;
    assign hit        = r_ref[r_ring_q];
    assign out_load   = i_cmd.grant_fin || i_cmd.sweep_eval || i_cmd.ack_apply;

    // Ring write port: the clearing pass fills bank 0, a grant rebuilds the
    // ring in the idle bank.
    always_comb begin
        w_we   = 1'b0;
        w_sel  = ~r_bank;
        w_addr = r_j;
        w_data = r_ring_q;
        priority if (i_cmd.init_step) begin
            w_we   = 1'b1;
            w_sel  = 1'b0;
            w_addr = r_idx;
            w_data = r_idx + 1'b1;
        end else if (i_cmd.grant_fin) begin
            w_we   = 1'b1;
            w_data = r_free_q;
        end else if (reord_keep) begin
            w_we = 1'b1;
        end else begin
            w_we = 1'b0;
        end
    end

    // Free list write port.
    always_comb begin
        f_we   = 1'b0;
        f_addr = r_tail;
        f_data = fi;
        priority if (i_cmd.init_step) begin
            f_we   = 1'b1;
            f_addr = r_idx;
            f_data = r_idx + 1'b1;
        end else if (i_cmd.ack_apply && frame_ok && r_op == OP_RELEASE && can_push) begin
            f_we = 1'b1;
        end else begin
            f_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && !w_sel) begin
            r_ring0[w_addr] <= w_data;
        end
        if (w_we && w_sel) begin
            r_ring1[w_addr] <= w_data;
        end
        if (ring_rd) begin
            r_ring_q <= r_bank ? r_ring1[ring_ra] : r_ring0[ring_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_free_mem[f_addr] <= f_data;
        end
        if (i_cmd.reord_start) begin
            r_free_q <= r_free_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages  <= CW'(RESET_PAGES);
            r_bank   <= 1'b0;
            r_hand   <= '0;
            r_rp     <= '0;
            r_krd    <= '0;
            r_j      <= '0;
            r_rq_vld <= 1'b0;
            r_head   <= '0;
            r_tail   <= AW'(RESET_PAGES - 1);
            r_count  <= CW'(RESET_PAGES - 1);
            r_ref    <= '0;
            r_dirty  <= '0;
            r_idx    <= '0;
        end else if (i_cfg_we) begin
            r_pages  <= n_pages;
            r_bank   <= 1'b0;
            r_hand   <= '0;
            r_rq_vld <= 1'b0;
            r_head   <= '0;
            r_tail   <= AW'(n_pages - 1'b1);
            r_count  <= n_pages - 1'b1;
            r_ref    <= '0;
            r_dirty  <= '0;
            r_idx    <= '0;
        end else begin
            if (i_cmd.init_step) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.reord_start) begin
                r_rp     <= r_hand;
                r_krd    <= '0;
                r_j      <= '0;
                r_rq_vld <= 1'b0;
                r_head   <= head_inc;
                r_count  <= r_count - 1'b1;
            end
            if (i_cmd.reord_run) begin
                if (reord_rd) begin
                    r_rp     <= rp_inc;
                    r_krd    <= r_krd + 1'b1;
                    r_rq_vld <= 1'b1;
                end else begin
                    r_rq_vld <= 1'b0;
                end
                if (reord_keep) begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (i_cmd.grant_fin) begin
                r_bank          <= ~r_bank;
                r_hand          <= '0;
                r_ref[r_free_q] <= 1'b1;
            end
            if (i_cmd.sweep_eval) begin
                r_hand <= hand_inc;
                if (hit) begin
                    r_ref[r_ring_q] <= 1'b0;
                end else begin
                    r_ref[r_ring_q]   <= 1'b1;
                    r_dirty[r_ring_q] <= 1'b0;
                end
            end
            if (i_cmd.ack_apply && frame_ok) begin
                if (r_op == OP_REF) begin
                    r_ref[fi] <= 1'b1;
                    if (r_wr) begin
                        r_dirty[fi] <= 1'b1;
                    end
                end else if (r_op == OP_RELEASE) begin
                    if (can_push) begin
                        r_tail  <= tail_inc;
                        r_count <= r_count + 1'b1;
                    end
                    r_ref[fi]   <= 1'b0;
                    r_dirty[fi] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_op;
            r_frame <= i_frame;
            r_wr    <= i_is_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grant_fin) begin
            r_kind      <= KIND_GRANT;
            r_frame_out <= FRAME_W'(r_free_q);
            r_wb        <= 1'b0;
            r_last      <= 1'b1;
        end else if (i_cmd.sweep_eval) begin
            r_kind      <= hit ? KIND_UNMAP : KIND_VICTIM;
            r_frame_out <= FRAME_W'(r_ring_q);
            r_wb        <= !hit && r_dirty[r_ring_q];
            r_last      <= !hit;
        end else if (i_cmd.ack_apply) begin
            r_kind      <= KIND_ACK;
            r_frame_out <= r_frame;
            r_wb        <= 1'b0;
            r_last      <= 1'b1;
        end
    end

    assign o_status.init_last  = (r_idx == LAST_IDX);
    assign o_status.op         = r_op;
    assign o_status.free_avail = (r_count != '0);
    assign o_status.reord_done = (r_krd == ring_len) && !r_rq_vld;
    assign o_status.sweep_hit  = hit;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_frame_out       = r_frame_out;
    assign o_needs_writeback = r_wb;
    assign o_last            = r_last;

endmodule

// File: hdl/clock_page_replacement.sv
`timescale 1ns / 1ps
// ============================================================================
// Clock page replacement
// Second-chance frame allocator with a FIFO free list for a pager.
// ============================================================================
// After reset and after every write of pages_in_use the block runs a clearing
// pass that fills the ring and the free list with frames 1 upward; o_in_stall
// stays high during that pass. Requests are taken one at a time. A reference,
// a release or an unused op code passes through a decode state and then an
// acknowledge state, which writes its acknowledge into the result register. An
// allocate that finds a free frame rebuilds the ring order from the hand with
// the granted frame moved to the tail, one ring entry per cycle through the
// single read port of the ring memory. An allocate with an empty free list
// sweeps the hand, reading each frame visited from the memory and then testing
// its reference bit, giving one unmap result for every referenced frame passed
// and ending on the victim; the sweep never visits more than pages_in_use
// frames. Results leave through a one-deep output register, so a stalled
// consumer holds the block only when a new result is ready to be written.
// Frame 0 is pinned; reference or release of frame 0 or of a frame at or above
// pages_in_use is acknowledged without any effect.
// ============================================================================
module clock_page_replacement #(
    parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration: pages_in_use.
    input  logic                         i_cfg_we,
    input  logic [cpr_pkg::PAGES_W-1:0]  i_cfg_data,
    // Request channel.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [cpr_pkg::OP_W-1:0]     i_op,
    input  logic [cpr_pkg::FRAME_W-1:0]  i_frame,
    input  logic                         i_is_write,
    // Result channel.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cpr_pkg::KIND_W-1:0]   o_kind,
    output logic [cpr_pkg::FRAME_W-1:0]  o_frame_out,
    output logic                         o_needs_writeback,
    output logic                         o_last
);
    import cpr_pkg::*;

    // The controller and the datapath talk only through these bundles.
    t_cmd    cmd;
    t_status status;

    cpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // The datapath holds all frame state; the request payload is captured
    // on the acceptance edge, when the controller issues its latch command.
    cpr_dpath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_frame           (i_frame),
        .i_is_write        (i_is_write),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_kind            (o_kind),
        .o_frame_out       (o_frame_out),
        .o_needs_writeback (o_needs_writeback),
        .o_last            (o_last)
    );

endmodule

// File: hdl/cpr_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Clock page replacement checker
// Port-level properties of the allocator, bound to the top level.
// ============================================================================
module cpr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic                        i_in_stall,
    input logic                        i_out_valid,
    input logic                        i_out_stall,
    input logic [cpr_pkg::KIND_W-1:0]  i_kind,
    input logic [cpr_pkg::FRAME_W-1:0] i_frame_out,
    input logic                        i_needs_writeback,
    input logic                        i_last
);
    import cpr_pkg::*;

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_kind)
            && $stable(i_frame_out) && $stable(i_needs_writeback) && $stable(i_last))
        else $error("stalled result changed");

    // Only a victim can ask for a write back.
    a_wb_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_needs_writeback |-> i_kind == KIND_VICTIM)
        else $error("write back on a result that is not a victim");

    // Every request ends on exactly one result marked last; unmaps never are.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_kind != KIND_UNMAP)))
        else $error("last flag does not match result kind");

    // The pinned frame is never granted, unmapped or evicted.
    a_pinned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != KIND_ACK |-> i_frame_out != '0)
        else $error("pinned frame handed out");

    // The clearing pass after reset or a register write blocks requests.
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n || i_cfg_we |=> i_in_stall)
        else $error("request taken during clearing pass");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cfg_we          (i_cfg_we),
    .i_in_stall        (o_in_stall),
    .i_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .i_kind            (o_kind),
    .i_frame_out       (o_frame_out),
    .i_needs_writeback (o_needs_writeback),
    .i_last            (o_last)
);

// File: verif/tb_clock_page_replacement.sv
`timescale 1ns / 1ps
// ============================================================================
// Clock page replacement testbench
// Sends allocate, reference and release requests to the frame allocator while
// both channels idle and stall at random. A behavioral copy of the clock ring,
// the hand, the reference and dirty bits and the free list predicts every
// grant, unmap, victim and acknowledge. Each result is checked field by field
// as it leaves the block. The run covers several frame counts, the clamped
// extremes among them.
// ============================================================================
module tb_clock_page_replacement;
    import cpr_pkg::*;

    // Op code 3 has no function, but the block must still acknowledge it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int NUM_FRAMES    = MAX_FRAMES_DEF;
    localparam int SETTLE_CYCLES = 8;
    // The longest single request is a full sweep.
    localparam int DRAIN_CYCLES  = 2 * NUM_FRAMES + 8;
    localparam int MAX_REPORTS   = 10;
    localparam int RUN_LIMIT_NS  = 6_000_000;
    localparam int NUM_ROWS      = 28;
    localparam int NUM_PHASES    = 8;

    // Row types of the directed plan.
    localparam logic ROW_REQ = 1'b0;
    localparam logic ROW_CFG = 1'b1;
    // Where the expected result of a directed row comes from.
    localparam logic WANT_PREDICTED = 1'b0;
    localparam logic WANT_TYPED     = 1'b1;

    typedef struct packed {
        t_kind              kind;
        logic [FRAME_W-1:0] frame;
        logic               writeback;
        logic               last;
    } t_page_event;

    typedef struct packed {
        logic               row_kind;
        logic [PAGES_W-1:0] cfg_value;
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] frame;
        logic               is_write;
        logic               typed;
        t_page_event        want;
    } t_plan_row;

    localparam t_page_event NO_EVENT = '0;

    // ------------------------------------------------------------------------
    // Signals of the block
    // ------------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [PAGES_W-1:0]  i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_op;
    logic [FRAME_W-1:0]  i_frame;
    logic                i_is_write;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [KIND_W-1:0]   o_kind;
    logic [FRAME_W-1:0]  o_frame_out;
    logic                o_needs_writeback;
    logic                o_last;

    clock_page_replacement dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_frame           (i_frame),
        .i_is_write        (i_is_write),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_frame_out       (o_frame_out),
        .o_needs_writeback (o_needs_writeback),
        .o_last            (o_last)
    );

    // ------------------------------------------------------------------------
    // Directed plan. The first rows run at the reset frame count of 64 and hit
    // the pinned frame, the top frame, the unused op code and a release into a
    // full free list. Then the count is clamped up from 0 to 2, where a single
    // frame forms the whole ring, and double releases queue the same frame
    // twice. The largest write value clamps down to 64. A ring of three frames
    // closes the plan with a sweep that passes a referenced frame. Results that
    // follow directly from the rules are typed in; sweeps are predicted.
    // ------------------------------------------------------------------------
    t_plan_row plan_rows [NUM_ROWS] = '{
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_TYPED, '{KIND_GRANT, 6'd1,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_REF,     6'd0,  1'b1, WANT_TYPED, '{KIND_ACK,   6'd0,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_REF,     6'd63, 1'b1, WANT_TYPED, '{KIND_ACK,   6'd63, 1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_RELEASE, 6'd0,  1'b0, WANT_TYPED, '{KIND_ACK,   6'd0,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_UNUSED,  6'd63, 1'b1, WANT_TYPED, '{KIND_ACK,   6'd63, 1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_RELEASE, 6'd63, 1'b0, WANT_TYPED, '{KIND_ACK,   6'd63, 1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_RELEASE, 6'd62, 1'b0, WANT_TYPED, '{KIND_ACK,   6'd62, 1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_RELEASE, 6'd61, 1'b1, WANT_TYPED, '{KIND_ACK,   6'd61, 1'b0, 1'b1}},
        '{ROW_CFG, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_PREDICTED, NO_EVENT},
        '{ROW_REQ, 7'd0,   OP_REF,     6'd1,  1'b1, WANT_TYPED, '{KIND_ACK,   6'd1,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_REF,     6'd2,  1'b0, WANT_TYPED, '{KIND_ACK,   6'd2,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_TYPED, '{KIND_GRANT, 6'd1,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_PREDICTED, NO_EVENT},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b1, WANT_PREDICTED, NO_EVENT},
        '{ROW_REQ, 7'd0,   OP_RELEASE, 6'd1,  1'b0, WANT_TYPED, '{KIND_ACK,   6'd1,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_RELEASE, 6'd1,  1'b0, WANT_TYPED, '{KIND_ACK,   6'd1,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_TYPED, '{KIND_GRANT, 6'd1,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_TYPED, '{KIND_GRANT, 6'd1,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_PREDICTED, NO_EVENT},
        '{ROW_CFG, 7'd127, OP_ALLOC,   6'd0,  1'b0, WANT_PREDICTED, NO_EVENT},
        '{ROW_REQ, 7'd0,   OP_REF,     6'd63, 1'b1, WANT_TYPED, '{KIND_ACK,   6'd63, 1'b0, 1'b1}},
        '{ROW_CFG, 7'd4,   OP_ALLOC,   6'd0,  1'b0, WANT_PREDICTED, NO_EVENT},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_TYPED, '{KIND_GRANT, 6'd1,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_TYPED, '{KIND_GRANT, 6'd2,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_TYPED, '{KIND_GRANT, 6'd3,  1'b0, 1'b1}},
        '{ROW_REQ, 7'd0,   OP_REF,     6'd2,  1'b1, WANT_PREDICTED, NO_EVENT},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_PREDICTED, NO_EVENT},
        '{ROW_REQ, 7'd0,   OP_ALLOC,   6'd0,  1'b0, WANT_PREDICTED, NO_EVENT}
    };

    // Register values of the random phases. The last phase draws its own.
    logic [PAGES_W-1:0] phase_pages [NUM_PHASES] = '{
        7'd1, 7'd127, 7'd5, 7'd0, 7'd9, 7'd3, 7'd70, 7'd2
    };

    // ------------------------------------------------------------------------
    // Pager state as the block should hold it.
    // ------------------------------------------------------------------------
    int unsigned        frames_total;
    logic [FRAME_W-1:0] ring_seq [NUM_FRAMES];
    int unsigned        hand_idx;
    bit                 refd [NUM_FRAMES];
    bit                 dirty [NUM_FRAMES];
    logic [FRAME_W-1:0] free_list [NUM_FRAMES];
    int unsigned        free_len;

    t_page_event        fresh_results [$];        // results of the latest request
    t_page_event        pending_page_events [$];  // results still due from the block

    t_page_event        seen_event;
    t_page_event        due_event;
    int                 error_count = 0;
    bit                 calm = 1'b0;               // no idling on either side

    function automatic t_page_event make_event(input t_kind kind,
                                               input logic [FRAME_W-1:0] frame,
                                               input logic writeback,
                                               input logic last);
        t_page_event ev;
        ev.kind      = kind;
        ev.frame     = frame;
        ev.writeback = writeback;
        ev.last      = last;
        return ev;
    endfunction

    // Every write of the frame count clamps it and rebuilds the ring and the
    // free list from frame 1 upward, exactly as a reset does.
    function automatic void restart_pager(input logic [PAGES_W-1:0] value);
        int unsigned v;
        int          k;
        v = value;
        if (v < MIN_PAGES) v = MIN_PAGES;
        if (v > NUM_FRAMES) v = NUM_FRAMES;
        frames_total = v;
        for (k = 0; k < NUM_FRAMES; k++) begin
            ring_seq[k]  = (k < v - 1) ? FRAME_W'(k + 1) : '0;
            free_list[k] = (k < v - 1) ? FRAME_W'(k + 1) : '0;
            refd[k]      = 1'b0;
            dirty[k]     = 1'b0;
        end
        hand_idx = 0;
        free_len = v - 1;
    endfunction

    // Work out the results of one accepted request and update the pager state.
    function automatic void predict_request(input logic [OP_W-1:0] op,
                                            input logic [FRAME_W-1:0] frame,
                                            input logic is_write);
        int unsigned        ring_len;
        int unsigned        j;
        int unsigned        k;
        int unsigned        unmaps;
        logic [FRAME_W-1:0] grant;
        logic [FRAME_W-1:0] cur;
        logic [FRAME_W-1:0] tmp [NUM_FRAMES + 1];
        bit                 in_ring;
        bit                 found;
        fresh_results.delete();
        ring_len = frames_total - 1;
        in_ring  = (frame != 0) && (frame < frames_total);
        if (op == OP_ALLOC && free_len > 0) begin
            // Grant the oldest free frame and rebuild the ring from the hand,
            // with the granted frame moved to the tail.
            grant = free_list[0];
            for (k = 0; k < NUM_FRAMES - 1; k++) free_list[k] = free_list[k + 1];
            free_list[NUM_FRAMES - 1] = '0;
            free_len--;
            j = 0;
            for (k = 0; k < ring_len; k++) begin
                cur = ring_seq[(hand_idx + k) % ring_len];
                if (cur != grant) begin
                    tmp[j] = cur;
                    j++;
                end
            end
            tmp[j] = grant;
            for (k = 0; k < ring_len; k++) ring_seq[k] = tmp[k];
            hand_idx    = 0;
            refd[grant] = 1'b1;
            fresh_results.push_back(make_event(KIND_GRANT, grant, 1'b0, 1'b1));
        end else if (op == OP_ALLOC) begin
            // Sweep: referenced frames get a second chance and are unmapped,
            // the first unreferenced frame is the victim.
            unmaps = 0;
            found  = 1'b0;
            while (!found) begin
                cur      = ring_seq[hand_idx % ring_len];
                hand_idx = (hand_idx + 1) % ring_len;
                if (refd[cur]) begin
                    refd[cur] = 1'b0;
                    if (unmaps < NUM_FRAMES - 1) begin
                        fresh_results.push_back(make_event(KIND_UNMAP, cur, 1'b0, 1'b0));
                        unmaps++;
                    end
                end else begin
                    fresh_results.push_back(make_event(KIND_VICTIM, cur, dirty[cur], 1'b1));
                    refd[cur]  = 1'b1;
                    dirty[cur] = 1'b0;
                    found      = 1'b1;
                end
            end
        end else begin
            if (op == OP_REF && in_ring) begin
                refd[frame] = 1'b1;
                if (is_write) dirty[frame] = 1'b1;
            end else if (op == OP_RELEASE && in_ring) begin
                // A double release queues the frame again; a full list drops it.
                if (free_len < NUM_FRAMES) begin
                    free_list[free_len] = frame;
                    free_len++;
                end
                refd[frame]  = 1'b0;
                dirty[frame] = 1'b0;
            end
            fresh_results.push_back(make_event(KIND_ACK, frame, 1'b0, 1'b1));
        end
    endfunction

    // Most gaps are zero or short; a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic note_mismatch(input string what, input t_page_event want,
                                 input t_page_event got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected kind %0d frame %0d writeback %0d last %0d,",
                     $realtime, what, want.kind, want.frame, want.writeback, want.last,
                     " got kind %0d frame %0d writeback %0d last %0d",
                     got.kind, got.frame, got.writeback, got.last);
        end
    endtask

    // Present one request, hold it until the block takes it, then record what
    // it should produce. The valid stays high on return so that a following
    // request can go out back to back.
    task automatic issue_request(input logic [OP_W-1:0] op,
                                 input logic [FRAME_W-1:0] frame,
                                 input logic is_write,
                                 input logic typed,
                                 input t_page_event want);
        int gap;
        int k;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_frame    <= frame;
        i_is_write <= is_write;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(op, frame, is_write);
        if (typed) begin
            pending_page_events.push_back(want);
        end else begin
            for (k = 0; k < fresh_results.size(); k++)
                pending_page_events.push_back(fresh_results[k]);
        end
    endtask

    // The register is only written with the block idle: every result in, a
    // short settling pause, then a one-cycle write pulse. The block then runs
    // its clearing pass, which shows up as a stall on the request side.
    task automatic set_page_count(input logic [PAGES_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_page_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        restart_pager(value);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock, run limit and result-side back-pressure
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The stall on the result side comes in bursts of random length, with
    // none at all while the calm flag is set.
    initial begin : result_backpressure
        int stall_len;
        i_out_stall <= 1'b0;
        forever begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            stall_len = calm ? 0 : pick_gap();
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: every result taken by the consumer must match the oldest
    // outstanding expectation in every field.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_event = make_event(t_kind'(o_kind), o_frame_out, o_needs_writeback, o_last);
            if (pending_page_events.size() == 0) begin
                note_mismatch("result with no request outstanding", NO_EVENT, seen_event);
            end else begin
                due_event = pending_page_events.pop_front();
                if (seen_event.kind !== due_event.kind ||
                    seen_event.frame !== due_event.frame ||
                    seen_event.writeback !== due_event.writeback ||
                    seen_event.last !== due_event.last) begin
                    note_mismatch("result differs", due_event, seen_event);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, the directed plan, then random phases at several frame
    // counts, and finally the drain and the verdict.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                 row;
        int                 ph;
        int                 n;
        int                 count;
        int                 alloc_pct;
        int                 pick;
        logic [PAGES_W-1:0] value;
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] frame;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_op       <= OP_ALLOC;
        i_frame    <= '0;
        i_is_write <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        restart_pager(PAGES_RESET);
        @(posedge i_clk);

        for (row = 0; row < NUM_ROWS; row++) begin
            if (plan_rows[row].row_kind == ROW_CFG) begin
                set_page_count(plan_rows[row].cfg_value);
            end else begin
                issue_request(plan_rows[row].op, plan_rows[row].frame,
                              plan_rows[row].is_write, plan_rows[row].typed,
                              plan_rows[row].want);
            end
        end

        // Sweeps only start once the free list is empty, so large rings get
        // long phases that are mostly allocates, with references mixed in to
        // leave referenced frames in the hand's way.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            value = (ph == NUM_PHASES - 1) ? PAGES_W'($urandom_range(2, 16)) : phase_pages[ph];
            set_page_count(value);
            count     = (frames_total >= 32) ? 75 : 10;
            alloc_pct = (frames_total >= 32) ? 90 : 55;
            for (n = 0; n < count; n++) begin
                if (n % 10 == 0) calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0)
                    frame = FRAME_W'($urandom_range(0, 63));
                else
                    frame = FRAME_W'($urandom_range(1, frames_total - 1));
                if ($urandom_range(0, 99) < alloc_pct) begin
                    op = OP_ALLOC;
                end else begin
                    pick = $urandom_range(0, 19);
                    if (pick < 11)      op = OP_REF;
                    else if (pick < 18) op = OP_RELEASE;
                    else                op = OP_UNUSED;
                end
                issue_request(op, frame, 1'($urandom_range(0, 1)), WANT_PREDICTED, NO_EVENT);
            end
        end

        i_in_valid <= 1'b0;
        calm = 1'b0;
        while (pending_page_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/cpr_pkg.sv
hdl/cpr_ctrl.sv
hdl/cpr_dpath.sv
hdl/clock_page_replacement.sv
hdl/cpr_checker.sv
verif/tb_clock_page_replacement.sv
